// ===== design/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg
// Types and widths shared by the contained circle pruner.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       circle_radius;
    logic                      last_circle;
  } circle_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] kept_x;
    logic signed [COORD_W-1:0] kept_y;
    logic [RADIUS_W-1:0]       kept_radius;
    logic                      kept_last;
    logic                      overflowed;
  } kept_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RADIUS_W-1:0]       radius;
  } entry_t;

endpackage

// ===== design/ccp_pair_test.sv =====
// ----------------------------------------------------------------------------
// ccp_pair_test
// Three-stage containment test of one circle pair: differences, squares,
// compare. Flags the smaller circle (a on equal radii) if inside the other.
// ----------------------------------------------------------------------------
module ccp_pair_test #(
  parameter int IW = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ccp_pkg::entry_t a,
  input  ccp_pkg::entry_t b,
  input  logic [IW-1:0]   idx_a,
  input  logic [IW-1:0]   idx_b,
  output logic            hit,
  output logic [IW-1:0]   victim,
  output logic            active
);
  import ccp_pkg::*;

  logic                s2_valid;
  logic [COORD_W-1:0]  s2_dx;
  logic [COORD_W-1:0]  s2_dy;
  logic [RADIUS_W-1:0] s2_rd;
  logic [IW-1:0]       s2_victim;

  logic                  s3_valid;
  logic [2*COORD_W-1:0]  s3_dx2;
  logic [2*COORD_W-1:0]  s3_dy2;
  logic [2*RADIUS_W-1:0] s3_rd2;
  logic [IW-1:0]         s3_victim;

  logic signed [COORD_W:0] diff_x;
  logic signed [COORD_W:0] diff_y;
  logic [COORD_W:0]        abs_x;
  logic [COORD_W:0]        abs_y;
  logic [2*COORD_W:0]      dist2;

  always_comb begin
    diff_x = {a.x[COORD_W-1], a.x} - {b.x[COORD_W-1], b.x};
    diff_y = {a.y[COORD_W-1], a.y} - {b.y[COORD_W-1], b.y};
    abs_x  = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : (COORD_W+1)'(diff_x);
    abs_y  = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : (COORD_W+1)'(diff_y);
    dist2  = {1'b0, s3_dx2} + {1'b0, s3_dy2};
  end

  always_ff @(posedge clk) begin
    s2_dx <= abs_x[COORD_W-1:0];
    s2_dy <= abs_y[COORD_W-1:0];
    if (a.radius > b.radius) begin
      s2_rd     <= a.radius - b.radius;
      s2_victim <= idx_b;
    end else begin
      s2_rd     <= b.radius - a.radius;
      s2_victim <= idx_a;
    end
    s3_dx2    <= s2_dx * s2_dx;
    s3_dy2    <= s2_dy * s2_dy;
    s3_rd2    <= s2_rd * s2_rd;
    s3_victim <= s2_victim;
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
      s3_valid <= s2_valid;
    end
  end

  assign hit    = s3_valid && (dist2 <= (2*COORD_W+1)'(s3_rd2));
  assign victim = s3_victim;
  assign active = in_valid | s2_valid | s3_valid;

endmodule

// ===== design/contained_circle_pruner_core.sv =====
// ----------------------------------------------------------------------------
// contained_circle_pruner_core
// Stores a set of circles, removes each one lying wholly inside another, and
// emits the survivors in load order.
// ----------------------------------------------------------------------------
// Load: one circle per cycle while busy is low; a circle with last_circle set
//   raises busy. For n stored circles the block then runs a pair test on every
//   pair (two read ports of the circle memory, one pair a cycle), drains the
//   test pipeline and emits one slot per stored circle. Results are strobed
//   one per cycle, gaps where a circle was removed. Synchronous reset empties
//   the set; memory is kept.
module contained_circle_pruner_core #(
  parameter int MAX_CIRCLES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ccp_pkg::circle_t circle,
  output logic             busy,
  output logic             kept_strobe,
  output ccp_pkg::kept_t   kept
);
  import ccp_pkg::*;

  localparam int IW = $clog2(MAX_CIRCLES);
  localparam int CW = $clog2(MAX_CIRCLES + 1);

  typedef enum logic [2:0] {LOAD, PRUNE, DRAIN, EMIT, FINISH} state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic                   overflow;
  logic [MAX_CIRCLES-1:0] keep;
  logic [CW-1:0]          pi;
  logic [CW-1:0]          pj;
  logic [CW-1:0]          idx;
  logic                   iss_d;
  logic [IW-1:0]          pi_d;
  logic [IW-1:0]          pj_d;
  logic                   e_valid;
  logic                   e_last;

  entry_t mem [MAX_CIRCLES];
  entry_t rd_a;
  entry_t rd_b;

  logic                   accept;
  logic                   store;
  logic                   issue;
  logic [IW-1:0]          addr_a;
  logic [MAX_CIRCLES-1:0] above;
  logic                   hit;
  logic [IW-1:0]          victim;
  logic                   pipe_active;

  assign accept = start && (state == LOAD);
  assign store  = accept && (count < CW'(MAX_CIRCLES));
  assign issue  = (state == PRUNE) && (pj < count);
  assign addr_a = (state == EMIT) ? idx[IW-1:0] : pi[IW-1:0];

  always_comb begin
    for (int k = 0; k < MAX_CIRCLES; k++) begin
      above[k] = keep[k] && (CW'(k) > idx) && (CW'(k) < count);
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[count[IW-1:0]] <= '{x: circle.center_x, y: circle.center_y,
                              radius: circle.circle_radius};
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[pj[IW-1:0]];
  end

  ccp_pair_test #(.IW(IW)) u_pair (
    .clk    (clk),
    .rst    (rst),
    .in_valid(iss_d),
    .a      (rd_a),
    .b      (rd_b),
    .idx_a  (pi_d),
    .idx_b  (pj_d),
    .hit    (hit),
    .victim (victim),
    .active (pipe_active)
  );

  always_ff @(posedge clk) begin
    pi_d <= pi[IW-1:0];
    pj_d <= pj[IW-1:0];
    if (rst) begin
      state    <= LOAD;
      count    <= '0;
      overflow <= 1'b0;
      keep     <= '1;
      iss_d    <= 1'b0;
      e_valid  <= 1'b0;
      e_last   <= 1'b0;
      pi       <= '0;
      pj       <= '0;
      idx      <= '0;
    end else begin
      iss_d   <= issue;
      e_valid <= 1'b0;
      if (hit) begin
        keep[victim] <= 1'b0;
      end
      case (state)
        LOAD: begin
          if (accept) begin
            if (store) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            if (circle.last_circle) begin
              state <= PRUNE;
              pi    <= '0;
              pj    <= CW'(1);
            end
          end
        end
        PRUNE: begin
          if ((CW+1)'(pj) + 1'b1 < (CW+1)'(count)) begin
            pj <= pj + 1'b1;
          end else if ((CW+1)'(pi) + 2'd2 < (CW+1)'(count)) begin
            pi <= pi + 1'b1;
            pj <= pi + 2'd2;
          end else begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!pipe_active) begin
            state <= EMIT;
            idx   <= '0;
          end
        end
        EMIT: begin
          e_valid <= keep[idx[IW-1:0]];
          e_last  <= ~|above;
          idx     <= idx + 1'b1;
          if (idx == count - 1'b1) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          state    <= LOAD;
          count    <= '0;
          overflow <= 1'b0;
          keep     <= '1;
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  assign busy        = (state != LOAD);
  assign kept_strobe = e_valid;

  always_comb begin
    kept.kept_x      = rd_a.x;
    kept.kept_y      = rd_a.y;
    kept.kept_radius = rd_a.radius;
    kept.kept_last   = e_last;
    kept.overflowed  = overflow;
  end

endmodule

// ===== design/ccp_checker.sv =====
// ----------------------------------------------------------------------------
// ccp_checker
// Port-level checks of the contained circle pruner, bound to the top level.
// ----------------------------------------------------------------------------
module ccp_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input ccp_pkg::circle_t circle,
  input logic             busy,
  input logic             kept_strobe,
  input ccp_pkg::kept_t   kept
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    kept_strobe |-> busy)
    else $error("result beat while idle");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && circle.last_circle) |=> busy)
    else $error("end of set did not start pruning");

  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && circle.last_circle))
    else $error("busy without end of set");

  a_after_last: assert property (@(posedge clk) disable iff (rst)
    (kept_strobe && kept.kept_last) |=> !kept_strobe)
    else $error("result beat after last kept circle");

endmodule

bind contained_circle_pruner_core ccp_checker u_ccp_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .circle     (circle),
  .busy       (busy),
  .kept_strobe(kept_strobe),
  .kept       (kept)
);
